// ----- src/dnp3_link_frame_checker_assert.svh -----
// Assertion macros for the DNP3 link frame checker.
// The macros expect i_clk and i_rst_n to be visible where they are used.
`ifndef DNP3_LINK_FRAME_CHECKER_ASSERT_SVH
`define DNP3_LINK_FRAME_CHECKER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DLFC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("dlfc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define DLFC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("dlfc assertion failed");

`endif

// ----- src/dlfc_pkg.sv -----
// Package for the DNP3 link frame checker: constants, error codes, state types
// and the CRC-16 and header check functions. Depends on nothing.
`timescale 1ns / 1ps

package dlfc_pkg;

    localparam int DATA_BLOCK_BYTES = 16;
    localparam int BLOCK_BYTES      = DATA_BLOCK_BYTES + 2;
    localparam int HEADER_BYTES     = 10;
    localparam int BLK_SHIFT        = $clog2(DATA_BLOCK_BYTES);

    localparam logic [7:0]  START_BYTE0     = 8'h05;
    localparam logic [7:0]  START_BYTE1     = 8'h64;
    localparam logic [7:0]  MIN_LENGTH      = 8'd5;
    localparam logic [15:0] ADDR_LIMIT      = 16'hFFF0;
    localparam logic [15:0] CRC_POLY        = 16'hA6BC;
    localparam logic [8:0]  MAX_FRAME_RESET = 9'd292;
    localparam logic [8:0]  INDEX_MAX       = 9'h1FF;

    localparam logic [3:0] FC_PRI_RESET_LINK   = 4'h0;
    localparam logic [3:0] FC_PRI_TEST_LINK    = 4'h2;
    localparam logic [3:0] FC_PRI_CONF_DATA    = 4'h3;
    localparam logic [3:0] FC_PRI_UNCONF_DATA  = 4'h4;
    localparam logic [3:0] FC_PRI_REQ_STATUS   = 4'h9;
    localparam logic [3:0] FC_SEC_ACK          = 4'h0;
    localparam logic [3:0] FC_SEC_NACK         = 4'h1;
    localparam logic [3:0] FC_SEC_LINK_STATUS  = 4'hB;

    typedef enum logic [3:0] {
        ERR_NONE      = 4'd0,
        ERR_START_LEN = 4'd1,
        ERR_TOO_BIG   = 4'd2,
        ERR_HDR_CRC   = 4'd3,
        ERR_DATA_CRC  = 4'd4,
        ERR_DEST      = 4'd5,
        ERR_SRC       = 4'd6,
        ERR_DIR       = 4'd7,
        ERR_FC        = 4'd8,
        ERR_SHORT     = 4'd9
    } t_err;

    typedef struct packed {
        logic [8:0]  byte_index;
        logic [4:0]  block_position;
        logic [15:0] crc;
        logic [15:0] held;
        logic [7:0]  control;
        logic [15:0] dest;
        logic [15:0] source;
        t_err        first_error;
    } t_frame_state;

    typedef struct packed {
        logic        frame_ok;
        t_err        error_code;
        logic [15:0] dest_address;
        logic [15:0] source_address;
        logic [7:0]  control_byte;
    } t_result;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'd0, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    // The CRC travels complemented, low byte first.
    function automatic logic crc_good(input logic [15:0] crc, input logic [15:0] held);
        logic [15:0] want;
        want = ~crc;
        return (held[15:8] == want[7:0]) && (held[7:0] == want[15:8]);
    endfunction

    // Total frame size implied by the length field; valid for lengths of 5 and up.
    function automatic logic [9:0] computed_size(input logic [7:0] len);
        logic [7:0] body;
        logic [7:0] chunks;
        logic [7:0] rem;
        logic [9:0] crcs;
        body   = len - MIN_LENGTH;
        chunks = body >> BLK_SHIFT;
        rem    = body & 8'(DATA_BLOCK_BYTES - 1);
        crcs   = 10'd2 + {1'b0, chunks, 1'b0} + ((rem != 8'd0) ? 10'd2 : 10'd0);
        return {2'd0, len} + 10'd3 + crcs;
    endfunction

    function automatic logic fc_allowed(input logic [7:0] ctrl);
        logic ok;
        ok = 1'b0;
        if (ctrl[6]) begin
            case (ctrl[3:0]) inside
                FC_PRI_RESET_LINK, FC_PRI_TEST_LINK, FC_PRI_CONF_DATA,
                FC_PRI_UNCONF_DATA, FC_PRI_REQ_STATUS: ok = 1'b1;
                default: ok = 1'b0;
            endcase
        end else begin
            case (ctrl[3:0]) inside
                FC_SEC_ACK, FC_SEC_NACK, FC_SEC_LINK_STATUS: ok = 1'b1;
                default: ok = 1'b0;
            endcase
        end
        return ok;
    endfunction

    function automatic t_err keep_first(input t_err cur, input t_err code);
        return (cur == ERR_NONE) ? code : cur;
    endfunction

endpackage

// ----- src/dlfc_in_if.sv -----
// Input byte channel of the DNP3 link frame checker.
// Depends on nothing but the handshake convention valid and ready.
`timescale 1ns / 1ps

interface dlfc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ----- src/dlfc_out_if.sv -----
// Result channel of the DNP3 link frame checker, one transaction per frame.
// Depends on dlfc_pkg for the error code type.
`timescale 1ns / 1ps

interface dlfc_out_if import dlfc_pkg::*;;
    logic        valid;
    logic        ready;
    logic        frame_ok;
    t_err        error_code;
    logic [15:0] dest_address;
    logic [15:0] source_address;
    logic [7:0]  control_byte;

    modport source (output valid, output frame_ok, output error_code, output dest_address,
                    output source_address, output control_byte, input ready);
    modport sink   (input valid, input frame_ok, input error_code, input dest_address,
                    input source_address, input control_byte, output ready);
endinterface

// ----- src/dlfc_frame_core.sv -----
// Per-byte frame state update of the DNP3 link frame checker: header capture,
// block CRC checks and the end-of-frame checks. Depends on dlfc_pkg.
`timescale 1ns / 1ps

module dlfc_frame_core import dlfc_pkg::*; (
    input  t_frame_state i_state,
    input  logic [7:0]   i_byte,
    input  logic         i_last,
    input  logic [8:0]   i_max_frame_bytes,
    output t_frame_state o_next_state,
    output t_result      o_result
);

    always_comb begin
        t_frame_state s;
        t_err         err;
        logic         in_header;
        logic [4:0]   block_len;
        t_result      res;

        s         = i_state;
        err       = i_state.first_error;
        in_header = i_state.byte_index < 9'(HEADER_BYTES);
        block_len = in_header ? 5'(HEADER_BYTES) : 5'(BLOCK_BYTES);

        case (i_state.byte_index)
            9'd0: begin
                if (i_byte != START_BYTE0) err = keep_first(err, ERR_START_LEN);
            end
            9'd1: begin
                if (i_byte != START_BYTE1) err = keep_first(err, ERR_START_LEN);
            end
            9'd2: begin
                if (i_byte < MIN_LENGTH) begin
                    err = keep_first(err, ERR_START_LEN);
                end else if (computed_size(i_byte) > {1'b0, i_max_frame_bytes}) begin
                    err = keep_first(err, ERR_TOO_BIG);
                end
            end
            9'd3: s.control = i_byte;
            9'd4: s.dest[7:0] = i_byte;
            9'd5: s.dest[15:8] = i_byte;
            9'd6: s.source[7:0] = i_byte;
            9'd7: s.source[15:8] = i_byte;
            default: ;
        endcase

        // The CRC runs two bytes behind, so the trailing CRC bytes are never fed to it.
        if (s.block_position >= 5'd2) begin
            s.crc = crc_byte(s.crc, s.held[15:8]);
        end
        s.held           = {s.held[7:0], i_byte};
        s.block_position = s.block_position + 5'd1;
        if (s.block_position >= block_len) begin
            if (!crc_good(s.crc, s.held)) begin
                err = keep_first(err, in_header ? ERR_HDR_CRC : ERR_DATA_CRC);
            end
            s.block_position = '0;
            s.crc            = '0;
            s.held           = '0;
        end

        if (s.byte_index != INDEX_MAX) begin
            s.byte_index = s.byte_index + 9'd1;
        end

        if (i_last) begin
            if (i_state.byte_index < 9'(HEADER_BYTES - 1)) begin
                err = keep_first(err, ERR_SHORT);
            end else begin
                if (s.block_position != 5'd0) begin
                    if (s.block_position <= 5'd2 || !crc_good(s.crc, s.held)) begin
                        err = keep_first(err, ERR_DATA_CRC);
                    end
                end
                if (s.dest >= ADDR_LIMIT) begin
                    err = keep_first(err, ERR_DEST);
                end else if (s.source >= ADDR_LIMIT) begin
                    err = keep_first(err, ERR_SRC);
                end else if (s.control[7]) begin
                    err = keep_first(err, ERR_DIR);
                end else if (!fc_allowed(s.control)) begin
                    err = keep_first(err, ERR_FC);
                end
            end
        end
        s.first_error = err;

        res.frame_ok       = (err == ERR_NONE);
        res.error_code     = err;
        res.dest_address   = s.dest;
        res.source_address = s.source;
        res.control_byte   = s.control;
        o_result           = res;

        if (i_last) begin
            o_next_state = '0;
        end else begin
            o_next_state = s;
        end
    end

endmodule

// ----- src/dnp3_link_frame_checker.sv -----
// DNP3 link frame checker. A byte is registered on acceptance and processed from that
// register; the frame's result is loaded into the output register when the last byte is
// processed. One byte per cycle is accepted, also while a result waits; only a last byte
// stalls, while the result register is full and not read.
// Reset (synchronous, active low) clears the frame state and the
// register max_frame_bytes returns to 292.
`timescale 1ns / 1ps
`include "dnp3_link_frame_checker_assert.svh"

module dnp3_link_frame_checker import dlfc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dlfc_in_if.sink    i_in,
    dlfc_out_if.source o_out,
    input  logic       i_cfg_we,
    input  logic [8:0] i_cfg_wdata
);

    logic [8:0]   r_max_frame_bytes;
    logic         r_in_valid;
    logic [7:0]   r_in_byte;
    logic         r_in_last;
    t_frame_state r_state;
    logic         r_out_valid;
    t_result      r_out;

    t_frame_state n_state;
    t_result      n_result;
    logic         w_advance;
    logic         w_frame_end;

    assign w_advance   = r_in_valid && (!r_in_last || !r_out_valid || o_out.ready);
    assign w_frame_end = w_advance && r_in_last;
    assign i_in.ready  = !r_in_valid || w_advance;

    dlfc_frame_core u_core (
        .i_state           (r_state),
        .i_byte            (r_in_byte),
        .i_last            (r_in_last),
        .i_max_frame_bytes (r_max_frame_bytes),
        .o_next_state      (n_state),
        .o_result          (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_frame_bytes <= MAX_FRAME_RESET;
            r_in_valid        <= 1'b0;
            r_state           <= '0;
            r_out_valid       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max_frame_bytes <= i_cfg_wdata;
            end
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (w_advance) begin
                r_state <= n_state;
            end
            if (w_frame_end) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.data_byte;
            r_in_last <= i_in.last_byte;
        end
        if (w_frame_end) begin
            r_out <= n_result;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.frame_ok       = r_out.frame_ok;
    assign o_out.error_code     = r_out.error_code;
    assign o_out.dest_address   = r_out.dest_address;
    assign o_out.source_address = r_out.source_address;
    assign o_out.control_byte   = r_out.control_byte;

    `DLFC_ASSERT_NXT(a_last_held, r_in_valid && r_in_last && !w_advance, r_in_valid && r_in_last)
    `DLFC_ASSERT_NXT(a_frame_end_clears, w_frame_end, r_state == '0)
    `DLFC_ASSERT_IMP(a_no_result_overwrite, w_frame_end && r_out_valid, o_out.ready)
    `DLFC_ASSERT_IMP(a_ok_code, r_out_valid, r_out.frame_ok == (r_out.error_code == ERR_NONE))

endmodule
